FILE: rtl/core/fac_pkg.sv
// Shared types and constants for the frustum box culling block.
`default_nettype none
package fac_pkg;

	// Fixed field widths of the beats.
	localparam int NORM_W   = 16;
	localparam int COORD_W  = 32;
	localparam int HALF_W   = 31;
	localparam int OFF_W    = 32;
	localparam int IDX_IN_W = 3;
	localparam int RPL_W    = 3;

	// Datapath widths: corner is exact, product and sum never overflow.
	localparam int CORNER_W  = COORD_W + 1;
	localparam int PROD_W    = NORM_W + CORNER_W;
	localparam int ACC_W     = 52;
	localparam int OFF_SHIFT = 15;

	// Command codes of an input beat.
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TEST = 1'b1
	} cmd_e;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             wr_en;
		logic             start;
		logic             issue;
		logic             finish;
		logic             fin_visible;
		logic [RPL_W-1:0] fin_plane;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/fac_ctrl.sv
// Controller: sequences plane evaluation and owns the handshake state.
`default_nettype none
module fac_ctrl #(
	parameter int NUM_PLANES = 6,
	parameter int IDX_W      = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          in_cmd,
	input  wire logic [fac_pkg::IDX_IN_W-1:0]  in_idx,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	input  wire logic                          neg,
	output logic [IDX_W-1:0]                   rd_idx,
	output fac_pkg::ctrl_cmd_t                 cmd_o
);
	import fac_pkg::*;

	localparam int CNT_W = $clog2(NUM_PLANES + 1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              valid_s1, valid_d;
	logic [IDX_W-1:0]  idx_s1, idx_d;
	logic              out_valid_q, out_valid_d;
	logic              finishing;
	logic              out_free;
	logic              stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Plane counter, stage one tracking and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q       <= cnt_d;
			valid_s1    <= valid_d;
			idx_s1      <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// A box finishes at its first negative plane or after its last plane.
	assign out_free  = !out_valid_q || out_ready;
	assign finishing = (state_q == ST_RUN) && valid_s1
		&& (neg || (idx_s1 == IDX_W'(NUM_PLANES - 1)));
	assign stall     = finishing && !out_free;
	assign rd_idx    = cnt_q[IDX_W-1:0];
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d           = state_q;
		cnt_d             = cnt_q;
		valid_d           = valid_s1;
		idx_d             = idx_s1;
		in_ready          = 1'b0;
		cmd_o             = '0;
		cmd_o.fin_visible = !neg;
		cmd_o.fin_plane   = neg ? RPL_W'(idx_s1) : RPL_W'(NUM_PLANES);
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				valid_d  = 1'b0;
				if (in_valid) begin
					if (in_cmd == CMD_TEST) begin
						cmd_o.start = 1'b1;
						cnt_d       = '0;
						state_d     = ST_RUN;
					end else begin
						cmd_o.wr_en = (32'(in_idx) < NUM_PLANES);
					end
				end
			end
			ST_RUN: begin
				if (finishing) begin
					if (!stall) begin
						cmd_o.finish = 1'b1;
						valid_d      = 1'b0;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd_o.issue = (cnt_q < CNT_W'(NUM_PLANES));
					valid_d     = cmd_o.issue;
					idx_d       = cnt_q[IDX_W-1:0];
					cnt_d       = cnt_q + CNT_W'(cmd_o.issue);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output beat is set on finish and cleared when taken.
	always_comb begin
		if (cmd_o.finish) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/fac_dp.sv
// Datapath: plane store, far-corner products and signed plane distance.
`default_nettype none
module fac_dp #(
	parameter int NUM_PLANES = 6,
	parameter int IDX_W      = 3
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire fac_pkg::ctrl_cmd_t                   cmd_i,
	input  wire logic [IDX_W-1:0]                     rd_idx,
	input  wire logic [fac_pkg::IDX_IN_W-1:0]         plane_index,
	input  wire logic signed [fac_pkg::NORM_W-1:0]    normal_x,
	input  wire logic signed [fac_pkg::NORM_W-1:0]    normal_y,
	input  wire logic signed [fac_pkg::NORM_W-1:0]    normal_z,
	input  wire logic signed [fac_pkg::OFF_W-1:0]     plane_offset,
	input  wire logic signed [fac_pkg::COORD_W-1:0]   center_x,
	input  wire logic signed [fac_pkg::COORD_W-1:0]   center_y,
	input  wire logic signed [fac_pkg::COORD_W-1:0]   center_z,
	input  wire logic [fac_pkg::HALF_W-1:0]           half_extent_x,
	input  wire logic [fac_pkg::HALF_W-1:0]           half_extent_y,
	input  wire logic [fac_pkg::HALF_W-1:0]           half_extent_z,
	output logic                                      neg,
	output logic                                      visible,
	output logic [fac_pkg::RPL_W-1:0]                 reject_plane
);
	import fac_pkg::*;

	logic signed [NORM_W-1:0]   nx_q [NUM_PLANES];
	logic signed [NORM_W-1:0]   ny_q [NUM_PLANES];
	logic signed [NORM_W-1:0]   nz_q [NUM_PLANES];
	logic signed [OFF_W-1:0]    off_q [NUM_PLANES];
	logic [IDX_W-1:0]           wr_idx;

	logic signed [COORD_W-1:0]  cx_q, cy_q, cz_q;
	logic [HALF_W-1:0]          hx_q, hy_q, hz_q;

	logic signed [NORM_W-1:0]   rnx, rny, rnz;
	logic signed [CORNER_W-1:0] kx, ky, kz;
	logic signed [PROD_W-1:0]   px_s1, py_s1, pz_s1;
	logic signed [OFF_W-1:0]    off_s1;
	logic signed [ACC_W-1:0]    acc;

	logic                       visible_q;
	logic [RPL_W-1:0]           reject_plane_q;

	assign wr_idx = IDX_W'(plane_index);

	// Plane store, cleared by reset and written by a load beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				nx_q[i]  <= '0;
				ny_q[i]  <= '0;
				nz_q[i]  <= '0;
				off_q[i] <= '0;
			end
		end else if (cmd_i.wr_en) begin
			nx_q[wr_idx]  <= normal_x;
			ny_q[wr_idx]  <= normal_y;
			nz_q[wr_idx]  <= normal_z;
			off_q[wr_idx] <= plane_offset;
		end
	end

	// Box held for the whole test.
	always_ff @(posedge clk) begin
		if (cmd_i.start) begin
			cx_q <= center_x;
			cy_q <= center_y;
			cz_q <= center_z;
			hx_q <= half_extent_x;
			hy_q <= half_extent_y;
			hz_q <= half_extent_z;
		end
	end

	// Far corner: add the half extent where the normal is positive.
	assign rnx = nx_q[rd_idx];
	assign rny = ny_q[rd_idx];
	assign rnz = nz_q[rd_idx];

	assign kx = (rnx > 0) ? (CORNER_W'(cx_q) + $signed({2'b00, hx_q}))
	                      : (CORNER_W'(cx_q) - $signed({2'b00, hx_q}));
	assign ky = (rny > 0) ? (CORNER_W'(cy_q) + $signed({2'b00, hy_q}))
	                      : (CORNER_W'(cy_q) - $signed({2'b00, hy_q}));
	assign kz = (rnz > 0) ? (CORNER_W'(cz_q) + $signed({2'b00, hz_q}))
	                      : (CORNER_W'(cz_q) - $signed({2'b00, hz_q}));

	// Stage one: one product per axis, registered.
	always_ff @(posedge clk) begin
		if (cmd_i.issue) begin
			px_s1  <= PROD_W'(rnx) * PROD_W'(kx);
			py_s1  <= PROD_W'(rny) * PROD_W'(ky);
			pz_s1  <= PROD_W'(rnz) * PROD_W'(kz);
			off_s1 <= off_q[rd_idx];
		end
	end

	// Stage two: exact sum with the offset aligned to the product scale.
	assign acc = ACC_W'(px_s1) + ACC_W'(py_s1) + ACC_W'(pz_s1)
		+ (ACC_W'(off_s1) <<< OFF_SHIFT);
	assign neg = acc[ACC_W-1];

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd_i.finish) begin
			visible_q      <= cmd_i.fin_visible;
			reject_plane_q <= cmd_i.fin_plane;
		end
	end

	assign visible      = visible_q;
	assign reject_plane = reject_plane_q;

endmodule
`default_nettype wire

FILE: rtl/core/frustum_aabb_cull_top.sv
// Top level of the frustum versus axis-aligned box culling block.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    cmd, plane_index, normal_x/y/z, plane_offset,
//                                   center_x/y/z, half_extent_x/y/z
//   out      out_valid / out_ready  visible, reject_plane
//
// A load beat gives no result. A test beat evaluates one stored plane per
// cycle through a two-stage product and sum pipeline and stops at the first
// plane that rejects the box. Reset clears every stored plane to zero, so
// all boxes are visible. A result waiting on out_ready does not block a
// new beat; a later test stalls at its last step until the output register
// frees.
`default_nettype none
module frustum_aabb_cull_top #(
	parameter int NUM_PLANES = 6
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                cmd,
	input  wire logic [fac_pkg::IDX_IN_W-1:0]        plane_index,
	input  wire logic signed [fac_pkg::NORM_W-1:0]   normal_x,
	input  wire logic signed [fac_pkg::NORM_W-1:0]   normal_y,
	input  wire logic signed [fac_pkg::NORM_W-1:0]   normal_z,
	input  wire logic signed [fac_pkg::OFF_W-1:0]    plane_offset,
	input  wire logic signed [fac_pkg::COORD_W-1:0]  center_x,
	input  wire logic signed [fac_pkg::COORD_W-1:0]  center_y,
	input  wire logic signed [fac_pkg::COORD_W-1:0]  center_z,
	input  wire logic [fac_pkg::HALF_W-1:0]          half_extent_x,
	input  wire logic [fac_pkg::HALF_W-1:0]          half_extent_y,
	input  wire logic [fac_pkg::HALF_W-1:0]          half_extent_z,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     visible,
	output logic [fac_pkg::RPL_W-1:0]                reject_plane
);
	import fac_pkg::*;

	localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

	ctrl_cmd_t        cmd_s;
	logic [IDX_W-1:0] rd_idx;
	logic             neg;

	// Sequencer.
	fac_ctrl #(
		.NUM_PLANES (NUM_PLANES),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_cmd    (cmd),
		.in_idx    (plane_index),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.neg       (neg),
		.rd_idx    (rd_idx),
		.cmd_o     (cmd_s)
	);

	// Plane store and arithmetic.
	fac_dp #(
		.NUM_PLANES (NUM_PLANES),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_i         (cmd_s),
		.rd_idx        (rd_idx),
		.plane_index   (plane_index),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.plane_offset  (plane_offset),
		.center_x      (center_x),
		.center_y      (center_y),
		.center_z      (center_z),
		.half_extent_x (half_extent_x),
		.half_extent_y (half_extent_y),
		.half_extent_z (half_extent_z),
		.neg           (neg),
		.visible       (visible),
		.reject_plane  (reject_plane)
	);

`ifndef NO_ASSERTIONS
	// A test beat keeps the block busy for at least the next cycle.
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_TEST) |=> !in_ready)
		else $error("input ready right after a test beat");

	// A finished test always presents a result beat.
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_s.finish |=> out_valid)
		else $error("finished test did not raise out_valid");

	// A visible box reports the plane count as its reject plane.
	a_visible_plane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && visible |-> reject_plane == RPL_W'(NUM_PLANES))
		else $error("visible result with a wrong reject plane");

	// Plane store is never written while a test runs.
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_s.wr_en |-> in_ready && !cmd_s.issue)
		else $error("plane write outside idle");
`endif

endmodule
`default_nettype wire

FILE: tb/frustum_aabb_cull_top_tb.sv
// Self-checking testbench for the six-plane frustum versus box culling block.
module frustum_aabb_cull_top_tb;
	import fac_pkg::*;

	localparam int NUM_PLANES  = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYC  = 20;

	// One input beat, all fields present whatever the command.
	typedef struct {
		cmd_e                      cmd;
		logic [IDX_IN_W-1:0]       pidx;
		logic signed [NORM_W-1:0]  nrm [3];
		logic signed [OFF_W-1:0]   off;
		logic signed [COORD_W-1:0] cen [3];
		logic [HALF_W-1:0]         half [3];
	} beat_t;

	// One culling verdict.
	typedef struct {
		logic             vis;
		logic [RPL_W-1:0] plane;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic cmd;
	logic [IDX_IN_W-1:0] plane_index;
	logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
	logic signed [OFF_W-1:0] plane_offset;
	logic signed [COORD_W-1:0] center_x, center_y, center_z;
	logic [HALF_W-1:0] half_extent_x, half_extent_y, half_extent_z;
	logic out_valid;
	logic out_ready;
	logic visible;
	logic [RPL_W-1:0] reject_plane;

	// Shadow copy of the plane store and the verdicts still owed.
	logic signed [NORM_W-1:0] shadow_nrm [NUM_PLANES][3];
	logic signed [OFF_W-1:0]  shadow_off [NUM_PLANES];
	verdict_t                 pending_verdicts [$];

	int send_gap_pct;
	int take_stall_pct;
	int mismatches;
	int loads_done;
	int loads_ignored;
	int boxes_done;
	int verdicts_checked;
	int verdict_hist [NUM_PLANES+1];
	int cycles;

	frustum_aabb_cull_top #(
		.NUM_PLANES(NUM_PLANES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.plane_index(plane_index),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.plane_offset(plane_offset),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z),
		.half_extent_x(half_extent_x),
		.half_extent_y(half_extent_y),
		.half_extent_z(half_extent_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.visible(visible),
		.reject_plane(reject_plane)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog on total run length.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles, %0d verdicts still owed", cycles,
					pending_verdicts.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Computes the verdict for a box against the shadow planes.
	function automatic verdict_t cull_box(input beat_t b);
		verdict_t r;
		longint   acc;
		longint   corner;
		longint   n;
		bit       done;
		r.vis = 1'b1;
		r.plane = RPL_W'(NUM_PLANES);
		done = 1'b0;
		for (int p = 0; p < NUM_PLANES; p++) begin
			if (!done) begin
				// Offset is Q16.16; products of Q1.15 and Q16.16 are Q.31.
				acc = longint'(shadow_off[p]) * 32768;
				for (int a = 0; a < 3; a++) begin
					n = longint'(shadow_nrm[p][a]);
					// Farthest corner along the normal; zero takes the minus side.
					if (n > 0)
						corner = longint'(b.cen[a]) + longint'(b.half[a]);
					else
						corner = longint'(b.cen[a]) - longint'(b.half[a]);
					acc += n * corner;
				end
				if (acc < 0) begin
					r.vis = 1'b0;
					r.plane = RPL_W'(p);
					done = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// Updates the shadow store or queues a verdict for an accepted beat.
	function automatic void track_beat(input beat_t b);
		verdict_t v;
		if (b.cmd == CMD_LOAD) begin
			loads_done++;
			if (b.pidx < NUM_PLANES) begin
				shadow_nrm[b.pidx] = b.nrm;
				shadow_off[b.pidx] = b.off;
			end else begin
				loads_ignored++;
			end
		end else begin
			v = cull_box(b);
			boxes_done++;
			verdict_hist[v.plane]++;
			pending_verdicts.push_back(v);
		end
	endfunction

	// Drives one beat after a random gap and holds it until accepted.
	task automatic send_beat(input beat_t b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= b.cmd;
		plane_index   <= b.pidx;
		normal_x      <= b.nrm[0];
		normal_y      <= b.nrm[1];
		normal_z      <= b.nrm[2];
		plane_offset  <= b.off;
		center_x      <= b.cen[0];
		center_y      <= b.cen[1];
		center_z      <= b.cen[2];
		half_extent_x <= b.half[0];
		half_extent_y <= b.half[1];
		half_extent_z <= b.half[2];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_beat(b);
	endtask

	// Holds the input idle until every owed verdict has come back.
	task automatic wait_verdicts_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_verdicts.size() != 0);
	endtask

	// Plane load beat; the box fields carry random filler.
	function automatic beat_t load_beat(input int idx, input int nx, input int ny,
		input int nz, input int off);
		beat_t b;
		b.cmd = CMD_LOAD;
		b.pidx = IDX_IN_W'(idx);
		b.nrm[0] = NORM_W'(nx);
		b.nrm[1] = NORM_W'(ny);
		b.nrm[2] = NORM_W'(nz);
		b.off = off;
		for (int a = 0; a < 3; a++) begin
			b.cen[a] = $urandom;
			b.half[a] = HALF_W'($urandom);
		end
		return b;
	endfunction

	// Box test beat; the plane fields carry random filler.
	function automatic beat_t box_beat(input int cx, input int cy, input int cz,
		input int hx, input int hy, input int hz);
		beat_t b;
		b.cmd = CMD_TEST;
		b.pidx = IDX_IN_W'($urandom);
		for (int a = 0; a < 3; a++)
			b.nrm[a] = NORM_W'($urandom);
		b.off = $urandom;
		b.cen[0] = cx;
		b.cen[1] = cy;
		b.cen[2] = cz;
		b.half[0] = HALF_W'(hx);
		b.half[1] = HALF_W'(hy);
		b.half[2] = HALF_W'(hz);
		return b;
	endfunction

	// Random value shapers: centers and half extents span the full range now and then but lie mostly near the origin.
	function automatic int rand_center();
		if ($urandom_range(3) == 0)
			return $urandom;
		return int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
	endfunction

	function automatic int rand_half();
		case ($urandom_range(3))
			0: return $urandom & 32'h7FFF_FFFF;
			1: return 0;
			default: return $urandom_range(0, 32'h0040_0000);
		endcase
	endfunction

	function automatic int rand_normal();
		case ($urandom_range(7))
			0: return 0;
			1: return 32'sh0000_7FFF;
			2: return -32768;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	function automatic int rand_offset();
		case ($urandom_range(7))
			0, 1: return $urandom;
			2: return -int'($urandom_range(0, 32'h0100_0000));
			default: return $urandom_range(0, 32'h4000_0000);
		endcase
	endfunction

	// Result side: random stalls, and every accepted verdict checked in order.
	initial begin
		verdict_t want;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					report_mismatch("verdict with none owed, reject_plane", reject_plane,
						NUM_PLANES);
				end else begin
					want = pending_verdicts.pop_front();
					verdicts_checked++;
					if (visible !== want.vis)
						report_mismatch("visible", visible, want.vis);
					if (reject_plane !== want.plane)
						report_mismatch("reject_plane", reject_plane, want.plane);
				end
			end
			out_ready <= ($urandom_range(99) >= take_stall_pct);
		end
	end

	// Planes are all zero after reset, so every box is visible.
	task automatic test_cleared_planes();
		send_beat(box_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_beat(box_beat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0));
	endtask

	// Loads to slots past the last plane leave the store alone.
	task automatic test_ignored_loads();
		send_beat(load_beat(6, 32767, 32767, 32767, 32'sh8000_0000));
		send_beat(load_beat(7, -32768, -32768, -32768, 32'sh8000_0000));
		send_beat(box_beat(32'sh8000_0000, 0, 0, 0, 0, 0));
	endtask

	// A sum of exactly zero is inside; one step further is outside.
	task automatic test_zero_sum_inside();
		send_beat(load_beat(0, -32768, 0, 0, 1));
		send_beat(box_beat(101, $urandom, $urandom, 100, $urandom, $urandom));
		send_beat(box_beat(102, $urandom, $urandom, 100, $urandom, $urandom));
	endtask

	// Staircase of planes along z so that each plane in turn is the first to reject.
	task automatic test_each_plane_rejects();
		for (int p = 0; p < NUM_PLANES; p++)
			send_beat(load_beat(p, 0, 0, 16384, -(p + 1) * 65536));
		for (int k = 0; k <= NUM_PLANES; k++)
			send_beat(box_beat($urandom, $urandom, k * 131072 + 4000 - 1000, 0, 0, 1000));
	endtask

	// Extreme normals, offsets and box fields through the full-width sum.
	task automatic test_extreme_values();
		send_beat(load_beat(0, 32767, -32768, 32767, 32'sh8000_0000));
		send_beat(box_beat(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_beat(box_beat(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0));
	endtask

	// Mixed loads and box tests with random content.
	task automatic test_random_traffic(input int beats, input int gap_pct,
		input int stall_pct, input bit with_drain);
		int idx;
		send_gap_pct = gap_pct;
		take_stall_pct = stall_pct;
		for (int i = 0; i < beats; i++) begin
			if (with_drain && i == beats / 2)
				wait_verdicts_drained();
			if ($urandom_range(99) < 15) begin
				// A few loads aim past the last plane and must be ignored.
				if ($urandom_range(9) == 0)
					idx = $urandom_range(NUM_PLANES, 7);
				else
					idx = $urandom_range(0, NUM_PLANES - 1);
				send_beat(load_beat(idx, rand_normal(), rand_normal(), rand_normal(),
					rand_offset()));
			end else begin
				send_beat(box_beat(rand_center(), rand_center(), rand_center(),
					rand_half(), rand_half(), rand_half()));
			end
		end
	endtask

	// Reset, directed tests, random phases, then drain and verdict.
	initial begin
		mismatches = 0;
		loads_done = 0;
		loads_ignored = 0;
		boxes_done = 0;
		verdicts_checked = 0;
		foreach (verdict_hist[i])
			verdict_hist[i] = 0;
		for (int p = 0; p < NUM_PLANES; p++) begin
			shadow_off[p] = '0;
			for (int a = 0; a < 3; a++)
				shadow_nrm[p][a] = '0;
		end
		send_gap_pct = 18;
		take_stall_pct = 46;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_LOAD;
		plane_index <= '0;
		normal_x <= '0;
		normal_y <= '0;
		normal_z <= '0;
		plane_offset <= '0;
		center_x <= '0;
		center_y <= '0;
		center_z <= '0;
		half_extent_x <= '0;
		half_extent_y <= '0;
		half_extent_z <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cleared_planes();
		test_ignored_loads();
		test_zero_sum_inside();
		test_each_plane_rejects();
		test_extreme_values();
		test_random_traffic(560, 18, 46, 1'b1);
		test_random_traffic(560, 46, 18, 1'b0);
		test_random_traffic(560, 0, 0, 1'b0);

		wait_verdicts_drained();
		repeat (SETTLE_CYC) @(posedge clk);

		$display("Covered %0d plane loads (%0d to unused slots) and %0d box tests, %0d checked",
			loads_done, loads_ignored, boxes_done, verdicts_checked);
		$display("First rejecting plane 0..5: %0d %0d %0d %0d %0d %0d, visible %0d",
			verdict_hist[0], verdict_hist[1], verdict_hist[2], verdict_hist[3],
			verdict_hist[4], verdict_hist[5], verdict_hist[NUM_PLANES]);
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d verdicts never arrived", mismatches,
				pending_verdicts.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: frustum_aabb_cull_top.f
rtl/core/fac_pkg.sv
rtl/core/fac_ctrl.sv
rtl/core/fac_dp.sv
rtl/core/frustum_aabb_cull_top.sv
tb/frustum_aabb_cull_top_tb.sv
